### rtl/core/pfe_pkg.sv
// pfe_pkg: shared types and constants of the periodic function evaluator
// used by pfe_div and periodic_function_evaluator; no dependencies

package pfe_pkg;

    localparam int ARG_W    = 32;  // argument and table entry width
    localparam int PERIOD_W = 7;   // domain period width
    localparam int CODOM_W  = 16;  // codomain period width
    localparam int QUOT_W   = 33;  // signed floor quotient width
    localparam int VALUE_W  = 49;  // result width
    localparam int INDEX_W  = 6;   // table index field width
    localparam int CNT_W    = 5;   // divider step counter width

    // item kind carried in tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // configuration register indexes
    localparam logic CFG_DOM_PERIOD   = 1'b0;
    localparam logic CFG_CODOM_PERIOD = 1'b1;

    // divider result; quot and rem are held until the next result, done is a pulse
    typedef struct packed {
        logic                     done;
        logic signed [QUOT_W-1:0] quot;
        logic [PERIOD_W-1:0]      rem;
    } t_div_res;

endpackage

### rtl/core/pfe_ram.sv
// pfe_ram: generic single write port, single read port ram with registered read
// no dependencies

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pfe_div.sv
// pfe_div: bit-serial floor divider of a signed 32-bit argument by a small period
// depends on pfe_pkg

module pfe_div import pfe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ARG_W-1:0] i_dividend,
    input  logic [PERIOD_W-1:0]     i_divisor,
    output t_div_res                o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [ARG_W-1:0]    r_dvd;   // magnitude in, quotient bits shift in at the bottom
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;
    logic                r_neg;
    t_div_res            r_res;

    logic [PERIOD_W:0]   trial;
    logic                qbit;
    logic [PERIOD_W-1:0] n_rem;
    logic [ARG_W-1:0]    mag;
    logic [QUOT_W-1:0]   quot_pos;

    assign trial    = {r_rem, r_dvd[ARG_W-1]};
    assign qbit     = (trial >= {1'b0, r_div});
    assign n_rem    = qbit ? PERIOD_W'(trial - {1'b0, r_div}) : PERIOD_W'(trial);
    assign mag      = i_dividend[ARG_W-1] ? ARG_W'(-i_dividend) : ARG_W'(i_dividend);
    assign quot_pos = {1'b0, r_dvd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res.done <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_res.done <= 1'b0;
                    if (i_start) begin
                        r_dvd   <= mag;
                        r_rem   <= '0;
                        r_div   <= i_divisor;
                        r_neg   <= i_dividend[ARG_W-1];
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_dvd <= {r_dvd[ARG_W-2:0], qbit};
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // floor quotient and non-negative remainder for either sign
                    if (!r_neg) begin
                        r_res.quot <= quot_pos;
                        r_res.rem  <= r_rem;
                    end else if (r_rem == '0) begin
                        r_res.quot <= -quot_pos;
                        r_res.rem  <= '0;
                    end else begin
                        r_res.quot <= ~quot_pos;
                        r_res.rem  <= r_div - r_rem;
                    end
                    r_res.done <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res = r_res;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.done |=> !r_res.done)
        else $error("divider done held longer than one cycle");

endmodule

### rtl/core/periodic_function_evaluator.sv
// periodic_function_evaluator: top level, stream ports, table ram, multiply and add
// depends on pfe_pkg, pfe_ram, pfe_div

// Computes value = table[a mod P] + Q * floor(a / P) for a signed 32-bit argument a,
// with floor division so the remainder is never negative. P (dom_period, 0 taken as 1,
// capped at TABLE_DEPTH and at 127) and Q (codom_period) are set via the cfg write port;
// the user must set them only while the block is idle; the block does not enforce it.
// A tuser = 0 transfer writes table entry index if below P and gives no result.
// A tuser = 1 transfer evaluates: the bit-serial divider loads, forms 32 quotient bits,
// fixes the sign; Q * quotient is registered as the table is read; the sum is registered
// once the output register is free, the input being held off until then. The result
// waits there while a new item is taken; unwritten table entries read back undefined.

module periodic_function_evaluator import pfe_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // index[5:0], entry_value[37:6], argument[69:38]
    input  logic          s_axis_tuser,   // mode
    // output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [55:0]   m_axis_tdata    // value[48:0]
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [PERIOD_W-1:0] DEPTH_CAP =
        (TABLE_DEPTH > 127) ? 7'd127 : PERIOD_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SUM
    } t_state;

    t_state                    r_state;
    logic [PERIOD_W-1:0]       r_dom_period;
    logic [CODOM_W-1:0]        r_codom_period;
    logic signed [VALUE_W-1:0] r_prod;
    logic                      r_out_valid;
    logic [VALUE_W-1:0]        r_out_data;

    logic [PERIOD_W-1:0]       p_eff;
    logic [INDEX_W-1:0]        in_index;
    logic [ARG_W-1:0]          in_entry;
    logic signed [ARG_W-1:0]   in_arg;
    logic                      in_xfer;
    logic                      div_start;
    logic                      tbl_we;
    logic [ARG_W-1:0]          tbl_rdata;
    t_div_res                  div_res;
    logic signed [CODOM_W:0]   codom_s;
    logic out_free;
    logic                      out_load;

    assign in_index = s_axis_tdata[5:0];
    assign in_entry = s_axis_tdata[37:6];
    assign in_arg   = $signed(s_axis_tdata[69:38]);

    always_comb begin
        if (r_dom_period == '0) begin
            p_eff = PERIOD_W'(1);
        end else if (r_dom_period > DEPTH_CAP) begin
            p_eff = DEPTH_CAP;
        end else begin
            p_eff = r_dom_period;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign div_start     = in_xfer && (s_axis_tuser == MODE_EVAL);
    assign tbl_we        = in_xfer && (s_axis_tuser == MODE_WRITE)
                           && ({1'b0, in_index} < p_eff);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == S_SUM) && out_free;
    assign codom_s       = $signed({1'b0, r_codom_period});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom_period   <= PERIOD_W'(1);
            r_codom_period <= CODOM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DOM_PERIOD:   r_dom_period   <= i_cfg_data[PERIOD_W-1:0];
                CFG_CODOM_PERIOD: r_codom_period <= i_cfg_data[CODOM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // table read of the remainder starts in the same cycle
                    if (div_res.done) begin
                        r_prod  <= VALUE_W'(codom_s) * VALUE_W'($signed(div_res.quot));
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out_data <= VALUE_W'($signed(tbl_rdata)) + r_prod;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_arg),
        .i_divisor  (p_eff),
        .o_res      (div_res)
    );

    pfe_ram #(
        .WIDTH (ARG_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (AW'(in_index)),
        .i_wdata (in_entry),
        .i_raddr (AW'(div_res.rem)),
        .o_rdata (tbl_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_data};

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_eval_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !s_axis_tready)
        else $error("input taken while an evaluation is in progress");

    a_rem_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (div_res.rem < p_eff))
        else $error("table address not below the domain period");

endmodule

### verif/periodic_function_evaluator_tb.sv
// periodic_function_evaluator_tb: self-checking bench for the periodic function evaluator,
// table loads and evaluations under random stalls, checked against a software prediction
// depends on pfe_pkg and periodic_function_evaluator
`timescale 1ns / 100ps

module periodic_function_evaluator_tb;
    import pfe_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int LATENCY        = 40;    // divide, multiply, add, with some slack
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 95;
    localparam int PHASES         = 12;

    class pfe_scoreboard;
        logic signed [31:0] entries [TABLE_DEPTH];
        logic [PERIOD_W-1:0] dom_reg;
        logic [CODOM_W-1:0]  codom_reg;
        logic [VALUE_W-1:0]  pending_values [$];
        int errors, evals, writes_stored, writes_ignored, results_seen;

        function new();
            dom_reg   = 1;
            codom_reg = 1;
        endfunction

        function void set_register(logic idx, logic [15:0] data);
            if (idx == CFG_DOM_PERIOD) begin
                dom_reg = data[PERIOD_W-1:0];
            end else begin
                codom_reg = data[CODOM_W-1:0];
            end
        endfunction

        // zero acts as one, anything past the table depth is capped
        function int period_in_use();
            int p;
            p = dom_reg;
            if (p == 0) p = 1;
            if (p > TABLE_DEPTH) p = TABLE_DEPTH;
            return p;
        endfunction

        // floor division, remainder kept non-negative
        function logic [VALUE_W-1:0] floor_periodic_value(logic signed [31:0] arg);
            longint a, p, q, r, v;
            p = period_in_use();
            a = arg;
            q = a / p;
            r = a % p;
            if (r < 0) begin
                r += p;
                q -= 1;
            end
            v = longint'(entries[r]) + longint'(codom_reg) * q;
            return v[VALUE_W-1:0];
        endfunction

        function void note_input(logic mode, logic [INDEX_W-1:0] idx,
                                 logic signed [31:0] entry, logic signed [31:0] arg);
            if (mode == MODE_WRITE) begin
                if (int'(idx) < period_in_use()) begin
                    entries[idx] = entry;
                    writes_stored++;
                end else begin
                    writes_ignored++;
                end
            end else begin
                pending_values.push_back(floor_periodic_value(arg));
                evals++;
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < 30) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic [55:0] data);
            logic [VALUE_W-1:0] want;
            results_seen++;
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("result %h with no evaluation pending",
                                          data[VALUE_W-1:0]));
            end else begin
                want = pending_values.pop_front();
                if (data[VALUE_W-1:0] !== want)
                    report_mismatch($sformatf("value got %h want %h",
                                              data[VALUE_W-1:0], want));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // index[5:0], entry_value[37:6], argument[69:38]
    logic        s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // value[48:0]

    pfe_scoreboard sb;
    int tx_gap_max;
    int rx_stall_max;
    int idle_cycles;

    periodic_function_evaluator #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // unused index, entry or argument fields carry random noise; the top two bits are zero
    task send_item(logic mode, logic [INDEX_W-1:0] idx, logic [31:0] entry, logic [31:0] arg);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, arg, entry, idx};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_input(mode, idx, entry, arg);
    endtask

    task write_entry(logic [INDEX_W-1:0] idx, logic [31:0] entry);
        send_item(MODE_WRITE, idx, entry, $urandom);
    endtask

    task evaluate(logic [31:0] arg);
        send_item(MODE_EVAL, INDEX_W'($urandom), $urandom, arg);
    endtask

    // write items give no result, so leave time for the last one to finish
    task drain;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_values.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task configure(logic [15:0] dom_data, logic [15:0] codom_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DOM_PERIOD;
        i_cfg_data <= dom_data;
        @(posedge i_clk);
        sb.set_register(CFG_DOM_PERIOD, dom_data);
        i_cfg_idx  <= CFG_CODOM_PERIOD;
        i_cfg_data <= codom_data;
        @(posedge i_clk);
        sb.set_register(CFG_CODOM_PERIOD, codom_data);
        i_cfg_we   <= 1'b0;
    endtask

    task edge_evaluations;
        int p;
        p = sb.period_in_use();
        evaluate(32'd0);
        evaluate(-32'sd1);
        evaluate(p - 1);
        evaluate(p);
        evaluate(-p);
        evaluate(-p - 1);
        evaluate(32'h7fff_ffff);
        evaluate(32'h8000_0000);
    endtask

    task random_items(int count);
        int p, pick, span;
        logic [31:0] arg;
        p = sb.period_in_use();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                if ($urandom_range(0, 3) != 0) begin
                    write_entry(INDEX_W'($urandom_range(0, p - 1)), $urandom);
                end else begin
                    write_entry(INDEX_W'($urandom_range(0, 63)), $urandom);
                end
            end else if (pick < 40) begin
                arg = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 200)
                                           : 32'h8000_0000 + $urandom_range(0, 200);
                evaluate(arg);
            end else if (pick < 70) begin
                span = 3 * p + 5;
                evaluate($urandom_range(0, 2 * span) - span);
            end else begin
                evaluate($urandom);
            end
        end
    endtask

    // receiver with random backpressure
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int fixed_dom [6];
        int fixed_codom [6];
        logic [15:0] dom_data, codom_data;
        int p;

        fixed_dom   = '{4, 64, 0, 127, 1, 37};
        fixed_codom = '{3, 65535, 0, 1, 65535, 1000};
        sb = new();
        idle_cycles   = 0;
        tx_gap_max    = 6;
        rx_stall_max  = 6;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_DOM_PERIOD;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= MODE_WRITE;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            // every third phase runs without any idling on either side
            tx_gap_max   = (ph % 3 == 2) ? 0 : 6;
            rx_stall_max = (ph % 3 == 2) ? 0 : 6;
            if (ph < 6) begin
                dom_data   = {9'($urandom), 7'(fixed_dom[ph])};
                codom_data = 16'(fixed_codom[ph]);
            end else begin
                dom_data   = 16'($urandom);
                codom_data = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
            end
            configure(dom_data, codom_data);
            p = sb.period_in_use();

            // load every entry in use so no evaluation reads an unwritten entry
            if (ph == 0) begin
                write_entry(INDEX_W'(0), 32'h8000_0000);
                write_entry(INDEX_W'(1), 32'hffff_ffff);
                write_entry(INDEX_W'(2), 32'h0000_0000);
                write_entry(INDEX_W'(3), 32'h7fff_ffff);
                write_entry(INDEX_W'(4), 32'h1234_5678);    // index equal to the period, dropped
                write_entry(INDEX_W'(63), 32'h1234_5678);   // index far out of range, dropped
            end else begin
                for (int i = 0; i < p; i++) write_entry(INDEX_W'(i), $urandom);
            end

            if (ph < 3) edge_evaluations();
            random_items(RANDOM_ITEMS);
            drain();
        end

        $display("covered %0d evaluations and %0d table writes (%0d dropped) over %0d settings",
                 sb.evals, sb.writes_stored + sb.writes_ignored, sb.writes_ignored, PHASES);
        $display("%0d results checked, %0d mismatches", sb.results_seen, sb.errors);
        if (sb.errors == 0 && sb.pending_values.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (sb.pending_values.size() != 0)
                $display("%0d expected values never arrived", sb.pending_values.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
